// ===== sv/min_time_cubic_trajectory_fit_unit_defines.svh =====
// Assertion macros shared by the trajectory fit unit.
// Include this header where assertions are written; it depends on nothing.
`ifndef MIN_TIME_CUBIC_TRAJECTORY_FIT_UNIT_DEFINES_SVH
`define MIN_TIME_CUBIC_TRAJECTORY_FIT_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define MTC_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define MTC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/mtc_pkg.sv =====
// Shared types, constants and helper functions of the trajectory fit unit.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps

package mtc_pkg;

    localparam int FRAC       = 16;
    localparam int ITER_LIMIT = 50;
    localparam int SCALE      = 1 << FRAC;
    localparam int TOL_TICKS  = (SCALE + 500) / 1000;
    localparam int TMIN_TICKS = (SCALE + 5) / 10;
    localparam int TMAX_TICKS = 10 * SCALE;

    localparam int FW    = 21;                       // input field width
    localparam int TW    = 20;                       // time and speed limit width
    localparam int CW    = 40;                       // coefficient width
    localparam int MW    = 44;                       // multiplier operand width
    localparam int PW    = 2 * MW;                   // product width
    localparam int DIVW  = 80;                       // divider width
    localparam int ITW   = $clog2(ITER_LIMIT + 1);
    localparam int DIVCW = $clog2(DIVW + 1);

    localparam int MUL_CHUNK = 16;
    localparam int MUL_STEPS = 3;
    localparam int MUL_BW    = MUL_CHUNK * MUL_STEPS;
    localparam int MUL_CW    = 2;

    localparam logic [TW-1:0] MAX_SPEED_RESET = TW'(163840);
    localparam logic [CW-1:0] LIM_POS = {1'b0, {(CW - 1){1'b1}}};
    localparam logic [CW-1:0] LIM_NEG = {1'b1, {(CW - 1){1'b0}}};

    localparam logic CFG_MAX_SPEED_J0 = 1'b0;
    localparam logic CFG_MAX_SPEED_J1 = 1'b1;

    typedef logic signed [FW-1:0] field_t;
    typedef logic [TW-1:0]        time_t;
    typedef logic [TW-1:0]        speed_t;
    typedef logic signed [CW-1:0] coef_t;

    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_OVER_SPEED = 2'd1,
        ST_ZERO_DISP  = 2'd2,
        ST_TOO_SHORT  = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        SGN_ZERO,
        SGN_POS,
        SGN_NEG
    } sgn_t;

    typedef enum logic [1:0] {
        EVT_LO,
        EVT_HI,
        EVT_MID
    } evt_t;

    typedef enum logic [2:0] {
        L_IDLE,
        L_PROD,
        L_SUM,
        L_MGO,
        L_MWAIT,
        L_CMP,
        L_CHECK,
        L_DONE
    } lane_state_t;

    typedef enum logic [3:0] {
        C_IDLE,
        C_SQ,
        C_CUBE,
        C_PROD,
        C_SUM,
        C_D1GO,
        C_D1WAIT,
        C_D2GO,
        C_D2WAIT,
        C_DONE
    } coef_state_t;

    typedef enum logic [2:0] {
        T_IDLE,
        T_CHECK,
        T_FIT,
        T_MERGE,
        T_COEF,
        T_LOAD
    } top_state_t;

    typedef struct packed {
        field_t disp;
        field_t v0;
        field_t v1;
        speed_t vmax;
    } lane_req_t;

    typedef struct packed {
        logic  done;
        logic  fail;
        time_t dur;
    } lane_res_t;

    function automatic logic [MW-1:0] mag_wide(input logic signed [MW:0] x);
        logic signed [MW:0] n;
        n = -x;
        return x[MW] ? MW'(n) : MW'(x);
    endfunction

    function automatic logic [FW-1:0] mag_field(input logic signed [FW-1:0] x);
        logic signed [FW-1:0] n;
        n = -x;
        return x[FW-1] ? n : x;
    endfunction

    // Both nonzero with the same sign: the product of the two signs is positive.
    function automatic logic sgn_same(input sgn_t a, input sgn_t b);
        return (a == SGN_POS && b == SGN_POS) || (a == SGN_NEG && b == SGN_NEG);
    endfunction

    // The product of the two signs is zero or positive.
    function automatic logic sgn_nonneg(input sgn_t a, input sgn_t b);
        return (a == SGN_ZERO) || (b == SGN_ZERO) || (a == b);
    endfunction

    function automatic coef_t round_sat(input logic neg, input logic [DIVW-1:0] q);
        logic [CW-1:0] lim;
        logic [CW-1:0] m;
        lim = neg ? LIM_NEG : LIM_POS;
        m   = (q > DIVW'(lim)) ? lim : q[CW-1:0];
        return neg ? coef_t'(-m) : coef_t'(m);
    endfunction

endpackage

// ===== sv/mtc_mul.sv =====
// Unsigned multiplier that forms a wide product by shifting and adding slices.
// One 16-bit slice of the second operand is taken per cycle; uses mtc_pkg.
`timescale 1ns / 1ps

module mtc_mul (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    input  logic [mtc_pkg::MW-1:0]  op_a,
    input  logic [mtc_pkg::MW-1:0]  op_b,
    output logic                    done,
    output logic [mtc_pkg::PW-1:0]  prod
);
    import mtc_pkg::*;

    logic [MW-1:0]           a_reg;
    logic [MUL_BW-1:0]       b_reg;
    logic [PW-1:0]           acc_reg;
    logic [MUL_CW-1:0]       cnt_reg;
    logic                    done_reg;
    logic [MW+MUL_CHUNK-1:0] part;
    logic [PW-1:0]           acc_next;

    assign part     = a_reg * b_reg[MUL_BW-1 -: MUL_CHUNK];
    assign acc_next = {acc_reg[PW-MUL_CHUNK-1:0], {MUL_CHUNK{1'b0}}} + PW'(part);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= (cnt_reg == MUL_CW'(1));
            if (start)
            begin
                cnt_reg <= MUL_CW'(MUL_STEPS);
            end
            else if (cnt_reg != '0)
            begin
                cnt_reg <= cnt_reg - MUL_CW'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            a_reg   <= op_a;
            b_reg   <= MUL_BW'(op_b);
            acc_reg <= '0;
        end
        else if (cnt_reg != '0)
        begin
            b_reg   <= b_reg << MUL_CHUNK;
            acc_reg <= acc_next;
        end
    end

    assign done = done_reg;
    assign prod = acc_reg;

endmodule

// ===== sv/mtc_lane.sv =====
// One bisection lane: searches one joint's duration at its speed limit.
// Uses mtc_pkg and three mtc_mul instances for the wide peak test.
`timescale 1ns / 1ps

module mtc_lane (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  mtc_pkg::lane_req_t req,
    output mtc_pkg::lane_res_t res
);
    import mtc_pkg::*;

    lane_state_t state_reg, state_next;
    evt_t        tgt_reg, tgt_next;
    time_t       lo_reg, lo_next;
    time_t       hi_reg, hi_next;
    time_t       t_reg, t_next;
    sgn_t        y0_reg, y0_next;
    sgn_t        y2_reg, y2_next;
    logic [ITW-1:0] iter_reg, iter_next;
    logic        fail_reg, fail_next;
    time_t       dur_reg, dur_next;

    logic signed [43:0] s2t_reg;
    logic signed [42:0] s1t_reg;
    logic signed [41:0] v0t_reg;
    logic [39:0]        vmt_reg;
    logic [MW-1:0]      a_mag_reg, bq_mag_reg, p_mag_reg, u_reg;
    logic               p_neg_reg, bq_neg_reg, bq_zero_reg;

    logic signed [22:0] s2;
    logic signed [21:0] s1;
    logic signed [20:0] ts;
    logic signed [MW:0] ds, a_w, bq_w, p_w;
    logic [MW-1:0]      u_w;

    logic          mul_start;
    logic          done_p, done_q, done_r;
    logic [PW-1:0] pm, qm, rm;
    logic [PW:0]   x_w;
    sgn_t          y_w;

    logic          move_lo, move_hi;
    time_t         lo_upd, hi_upd, mid_w;
    logic [TW:0]   mid_sum;
    logic signed [TW:0] gap_w;
    logic [TW:0]   gap_mag;

    assign ts = signed'({1'b0, t_reg});
    assign s2 = (23'($signed(req.v0)) <<< 1) + 23'($signed(req.v1));
    assign s1 = 22'($signed(req.v0)) + 22'($signed(req.v1));

    assign ds   = (MW + 1)'($signed(req.disp)) <<< FRAC;
    assign a_w  = ds + (ds <<< 1) - (MW + 1)'(s2t_reg);
    assign bq_w = (MW + 1)'(s1t_reg) - (ds <<< 1);
    assign p_w  = (MW + 1)'(v0t_reg) + ((MW + 1)'(v0t_reg) <<< 1);
    assign u_w  = MW'(vmt_reg) + (MW'(vmt_reg) << 1);

    mtc_mul u_mul_p (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mul_start),
        .op_a  (p_mag_reg),
        .op_b  (bq_mag_reg),
        .done  (done_p),
        .prod  (pm)
    );

    mtc_mul u_mul_q (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mul_start),
        .op_a  (a_mag_reg),
        .op_b  (a_mag_reg),
        .done  (done_q),
        .prod  (qm)
    );

    mtc_mul u_mul_r (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mul_start),
        .op_a  (u_reg),
        .op_b  (bq_mag_reg),
        .done  (done_r),
        .prod  (rm)
    );

    // Peak test sign: compare |p*b - a^2| (or the sum when signs differ) with 3*vmax*t*|b|.
    always_comb
    begin
        if (p_neg_reg != bq_neg_reg)
        begin
            x_w = (PW + 1)'(pm) + (PW + 1)'(qm);
        end
        else if (pm >= qm)
        begin
            x_w = (PW + 1)'(pm - qm);
        end
        else
        begin
            x_w = (PW + 1)'(qm - pm);
        end
        if (bq_zero_reg)
        begin
            y_w = SGN_POS;
        end
        else if (x_w > (PW + 1)'(rm))
        begin
            y_w = SGN_POS;
        end
        else if (x_w == (PW + 1)'(rm))
        begin
            y_w = SGN_ZERO;
        end
        else
        begin
            y_w = SGN_NEG;
        end
    end

    assign mid_sum = {1'b0, lo_reg} + {1'b0, hi_reg};
    assign mid_w   = mid_sum[TW:1];
    assign move_lo = sgn_nonneg(y0_reg, y_w);
    assign move_hi = sgn_nonneg(y_w, y2_reg);
    assign lo_upd  = move_lo ? t_reg : lo_reg;
    assign hi_upd  = move_hi ? t_reg : hi_reg;
    assign gap_w   = signed'({1'b0, hi_upd}) - signed'({1'b0, lo_upd});
    assign gap_mag = gap_w[TW] ? (TW + 1)'(-gap_w) : (TW + 1)'(gap_w);

    always_comb
    begin
        state_next = state_reg;
        tgt_next   = tgt_reg;
        lo_next    = lo_reg;
        hi_next    = hi_reg;
        t_next     = t_reg;
        y0_next    = y0_reg;
        y2_next    = y2_reg;
        iter_next  = iter_reg;
        fail_next  = fail_reg;
        dur_next   = dur_reg;
        mul_start  = 1'b0;
        case (state_reg)
            L_IDLE, L_DONE:
            begin
                if (start)
                begin
                    lo_next    = TW'(TMIN_TICKS);
                    hi_next    = TW'(TMAX_TICKS);
                    t_next     = TW'(TMIN_TICKS);
                    tgt_next   = EVT_LO;
                    iter_next  = '0;
                    fail_next  = 1'b0;
                    state_next = L_PROD;
                end
            end
            L_PROD:
            begin
                state_next = L_SUM;
            end
            L_SUM:
            begin
                state_next = L_MGO;
            end
            L_MGO:
            begin
                mul_start  = 1'b1;
                state_next = L_MWAIT;
            end
            L_MWAIT:
            begin
                if (done_p && done_q && done_r)
                begin
                    state_next = L_CMP;
                end
            end
            L_CMP:
            begin
                case (tgt_reg)
                    EVT_LO:
                    begin
                        y0_next    = y_w;
                        t_next     = hi_reg;
                        tgt_next   = EVT_HI;
                        state_next = L_PROD;
                    end
                    EVT_HI:
                    begin
                        y2_next    = y_w;
                        state_next = L_CHECK;
                    end
                    default:
                    begin
                        // A moved bracket end inherits the midpoint's sign.
                        lo_next   = lo_upd;
                        hi_next   = hi_upd;
                        y0_next   = move_lo ? y_w : y0_reg;
                        y2_next   = move_hi ? y_w : y2_reg;
                        iter_next = iter_reg + ITW'(1);
                        if (gap_mag < (TW + 1)'(TOL_TICKS) ||
                            iter_reg == ITW'(ITER_LIMIT - 1))
                        begin
                            dur_next   = hi_upd;
                            state_next = L_DONE;
                        end
                        else
                        begin
                            state_next = L_CHECK;
                        end
                    end
                endcase
            end
            L_CHECK:
            begin
                if (sgn_same(y0_reg, y2_reg))
                begin
                    fail_next  = 1'b1;
                    state_next = L_DONE;
                end
                else
                begin
                    t_next     = mid_w;
                    tgt_next   = EVT_MID;
                    state_next = L_PROD;
                end
            end
            default:
            begin
                state_next = L_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= L_IDLE;
            tgt_reg   <= EVT_LO;
            lo_reg    <= '0;
            hi_reg    <= '0;
            t_reg     <= '0;
            y0_reg    <= SGN_ZERO;
            y2_reg    <= SGN_ZERO;
            iter_reg  <= '0;
            fail_reg  <= 1'b0;
            dur_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            tgt_reg   <= tgt_next;
            lo_reg    <= lo_next;
            hi_reg    <= hi_next;
            t_reg     <= t_next;
            y0_reg    <= y0_next;
            y2_reg    <= y2_next;
            iter_reg  <= iter_next;
            fail_reg  <= fail_next;
            dur_reg   <= dur_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == L_PROD)
        begin
            s2t_reg <= s2 * ts;
            s1t_reg <= s1 * ts;
            v0t_reg <= $signed(req.v0) * ts;
            vmt_reg <= req.vmax * t_reg;
        end
        if (state_reg == L_SUM)
        begin
            a_mag_reg   <= mag_wide(a_w);
            bq_mag_reg  <= mag_wide(bq_w);
            p_mag_reg   <= mag_wide(p_w);
            u_reg       <= u_w;
            p_neg_reg   <= p_w[MW];
            bq_neg_reg  <= bq_w[MW];
            bq_zero_reg <= (bq_w == '0);
        end
    end

    assign res.done = (state_reg == L_DONE);
    assign res.fail = fail_reg;
    assign res.dur  = dur_reg;

endmodule

// ===== sv/mtc_div.sv =====
// Restoring divider, one quotient bit per cycle.
// Uses mtc_pkg for its widths.
`timescale 1ns / 1ps

module mtc_div (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    input  logic [mtc_pkg::DIVW-1:0] dividend,
    input  logic [mtc_pkg::DIVW-1:0] divisor,
    output logic                    done,
    output logic [mtc_pkg::DIVW-1:0] quot
);
    import mtc_pkg::*;

    logic [DIVW-1:0]  num_reg, den_reg, quo_reg;
    logic [DIVW:0]    rem_reg;
    logic [DIVCW-1:0] cnt_reg;
    logic             done_reg;
    logic [DIVW:0]    rem_sh;
    logic             take;

    assign rem_sh = {rem_reg[DIVW-1:0], num_reg[DIVW-1]};
    assign take   = (rem_sh >= {1'b0, den_reg});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= (cnt_reg == DIVCW'(1));
            if (start)
            begin
                cnt_reg <= DIVCW'(DIVW);
            end
            else if (cnt_reg != '0)
            begin
                cnt_reg <= cnt_reg - DIVCW'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            num_reg <= dividend;
            den_reg <= divisor;
            rem_reg <= '0;
            quo_reg <= '0;
        end
        else if (cnt_reg != '0)
        begin
            num_reg <= num_reg << 1;
            rem_reg <= take ? rem_sh - {1'b0, den_reg} : rem_sh;
            quo_reg <= {quo_reg[DIVW-2:0], take};
        end
    end

    assign done = done_reg;
    assign quot = quo_reg;

endmodule

// ===== sv/mtc_coef.sv =====
// Coefficient stage: linear and quadratic velocity terms of both joints.
// Uses mtc_pkg and one shared mtc_div for the four rounded quotients.
`timescale 1ns / 1ps

module mtc_coef (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  mtc_pkg::time_t     tm,
    input  mtc_pkg::lane_req_t req [2],
    output logic               done,
    output mtc_pkg::coef_t     c1 [2],
    output mtc_pkg::coef_t     c2 [2]
);
    import mtc_pkg::*;

    coef_state_t state_reg, state_next;
    logic        j_reg, j_next;

    time_t              tm_reg;
    logic [2*TW-1:0]    tm2_reg;
    logic [3*TW-1:0]    tm3_reg;
    logic signed [43:0] s2t_reg;
    logic signed [42:0] s1t_reg;
    logic [MW-1:0]      a_mag_reg, bq_mag_reg;
    logic               a_neg_reg, bq_neg_reg;
    coef_t              c1_reg [2];
    coef_t              c2_reg [2];

    lane_req_t          rq;
    logic signed [22:0] s2;
    logic signed [21:0] s1;
    logic signed [20:0] ts;
    logic signed [MW:0] ds, a_w, bq_w;
    logic [MW+1:0]      bq3;
    logic [DIVW-1:0]    div1_num, div1_den, div2_num, div2_den;
    logic [DIVW-1:0]    div_num, div_den, quot;
    logic               div_start, div_done;

    assign rq = req[j_reg];
    assign ts = signed'({1'b0, tm_reg});
    assign s2 = (23'($signed(rq.v0)) <<< 1) + 23'($signed(rq.v1));
    assign s1 = 22'($signed(rq.v0)) + 22'($signed(rq.v1));

    assign ds   = (MW + 1)'($signed(rq.disp)) <<< FRAC;
    assign a_w  = ds + (ds <<< 1) - (MW + 1)'(s2t_reg);
    assign bq_w = (MW + 1)'(s1t_reg) - (ds <<< 1);

    // Rounded quotient (2n + d) / 2d for each term.
    assign bq3      = (MW + 2)'(bq_mag_reg) + ((MW + 2)'(bq_mag_reg) << 1);
    assign div1_num = (DIVW'(a_mag_reg) << (FRAC + 2)) + DIVW'(tm2_reg);
    assign div1_den = DIVW'(tm2_reg) << 1;
    assign div2_num = (DIVW'(bq3) << (2 * FRAC + 1)) + DIVW'(tm3_reg);
    assign div2_den = DIVW'(tm3_reg) << 1;

    assign div_start = (state_reg == C_D1GO) || (state_reg == C_D2GO);
    assign div_num   = (state_reg == C_D2GO) ? div2_num : div1_num;
    assign div_den   = (state_reg == C_D2GO) ? div2_den : div1_den;

    mtc_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_num),
        .divisor  (div_den),
        .done     (div_done),
        .quot     (quot)
    );

    always_comb
    begin
        state_next = state_reg;
        j_next     = j_reg;
        case (state_reg)
            C_IDLE, C_DONE:
            begin
                if (start)
                begin
                    j_next     = 1'b0;
                    state_next = C_SQ;
                end
            end
            C_SQ:     state_next = C_CUBE;
            C_CUBE:   state_next = C_PROD;
            C_PROD:   state_next = C_SUM;
            C_SUM:    state_next = C_D1GO;
            C_D1GO:   state_next = C_D1WAIT;
            C_D1WAIT:
            begin
                if (div_done)
                begin
                    state_next = C_D2GO;
                end
            end
            C_D2GO:   state_next = C_D2WAIT;
            C_D2WAIT:
            begin
                if (div_done)
                begin
                    if (j_reg)
                    begin
                        state_next = C_DONE;
                    end
                    else
                    begin
                        j_next     = 1'b1;
                        state_next = C_PROD;
                    end
                end
            end
            default:  state_next = C_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= C_IDLE;
            j_reg     <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            j_reg     <= j_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if ((state_reg == C_IDLE || state_reg == C_DONE) && start)
        begin
            tm_reg <= tm;
        end
        if (state_reg == C_SQ)
        begin
            tm2_reg <= tm_reg * tm_reg;
        end
        if (state_reg == C_CUBE)
        begin
            tm3_reg <= tm2_reg * tm_reg;
        end
        if (state_reg == C_PROD)
        begin
            s2t_reg <= s2 * ts;
            s1t_reg <= s1 * ts;
        end
        if (state_reg == C_SUM)
        begin
            a_mag_reg  <= mag_wide(a_w);
            bq_mag_reg <= mag_wide(bq_w);
            a_neg_reg  <= a_w[MW];
            bq_neg_reg <= bq_w[MW];
        end
        if (state_reg == C_D1WAIT && div_done)
        begin
            c1_reg[j_reg] <= round_sat(a_neg_reg, quot);
        end
        if (state_reg == C_D2WAIT && div_done)
        begin
            c2_reg[j_reg] <= round_sat(bq_neg_reg, quot);
        end
    end

    assign done  = (state_reg == C_DONE);
    assign c1[0] = c1_reg[0];
    assign c1[1] = c1_reg[1];
    assign c2[0] = c2_reg[0];
    assign c2[1] = c2_reg[1];

endmodule

// ===== sv/min_time_cubic_trajectory_fit_unit.sv =====
// Top level of the minimum-time cubic trajectory fit unit.
// Uses mtc_pkg, mtc_lane, mtc_coef and the assertion macro header.
//
// Usage: one request word on the input channel (in_valid, in_stall) carries
// displacement, start and end velocity of two joints. One result word leaves on
// the output channel (out_valid, out_stall) with a status, the duration and the
// velocity quadratic of each joint. A word moves when valid is high and stall is
// low. The speed limits are written through cfg_valid/cfg_ready (always ready)
// with cfg_index selecting the joint; write them only while the block is idle.
// Flow: the two joint searches run side by side in their own lanes, each
// bisection step being one wide peak test, with 14 steps typical and 50 at
// most. The coefficient stage then runs, with its divider used four times.
// Requests that fail the speed or zero-displacement check skip the search and
// go from the check step straight to the result load.
// One request is in work at a time; in_stall is high while it is.
// A finished result sits in the output register; the next request is accepted
// while it waits, and its own result waits until the receiver takes the first.
// Reset clears all control state and sets both speed limits to 2.5.
`timescale 1ns / 1ps
`include "min_time_cubic_trajectory_fit_unit_defines.svh"

module min_time_cubic_trajectory_fit_unit (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  mtc_pkg::field_t       disp_joint0,
    input  mtc_pkg::field_t       disp_joint1,
    input  mtc_pkg::field_t       start_speed_joint0,
    input  mtc_pkg::field_t       start_speed_joint1,
    input  mtc_pkg::field_t       end_speed_joint0,
    input  mtc_pkg::field_t       end_speed_joint1,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [1:0]            status,
    output logic [19:0]           duration,
    output mtc_pkg::field_t       coef_const_joint0,
    output mtc_pkg::coef_t        coef_lin_joint0,
    output mtc_pkg::coef_t        coef_quad_joint0,
    output mtc_pkg::field_t       coef_const_joint1,
    output mtc_pkg::coef_t        coef_lin_joint1,
    output mtc_pkg::coef_t        coef_quad_joint1,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic                  cfg_index,
    input  logic [19:0]           cfg_data
);
    import mtc_pkg::*;

    top_state_t state_reg, state_next;
    status_t    status_reg, status_next;
    time_t      tm_reg, tm_next;
    speed_t     vm0_reg, vm1_reg;

    lane_req_t  req_reg [2];
    logic       zd_reg [2];

    logic       out_valid_reg, out_valid_next;
    status_t    status_o_reg;
    time_t      duration_reg;
    field_t     c0_reg [2];
    coef_t      c1_o_reg [2];
    coef_t      c2_o_reg [2];

    logic       accept, lane_start, coef_start, load_ok;
    lane_res_t  res [2];
    coef_t      c1_w [2];
    coef_t      c2_w [2];
    logic       coef_done;

    logic       over_w, zdbad_w;
    logic       zd_w [2];
    logic       ok0, ok1, short_w;
    time_t      t0, t1, tm_w;

    assign accept    = in_valid && !in_stall;
    assign in_stall  = (state_reg != T_IDLE);
    assign cfg_ready = 1'b1;

    // Speed limits; a write is taken in any cycle.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vm0_reg <= MAX_SPEED_RESET;
            vm1_reg <= MAX_SPEED_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_MAX_SPEED_J0: vm0_reg <= cfg_data;
                CFG_MAX_SPEED_J1: vm1_reg <= cfg_data;
                default:          vm0_reg <= vm0_reg;
            endcase
        end
    end

    // Request checks that settle the status before any search is started.
    // A joint that does not move needs no search; it only must keep its speed.
    always_comb
    begin
        over_w  = 1'b0;
        zdbad_w = 1'b0;
        for (int j = 0; j < 2; j++)
        begin
            if (mag_field(req_reg[j].v0) > {1'b0, req_reg[j].vmax} ||
                mag_field(req_reg[j].v1) > {1'b0, req_reg[j].vmax})
            begin
                over_w = 1'b1;
            end
            zd_w[j] = (mag_field(req_reg[j].disp) < FW'(TOL_TICKS));
            if (zd_w[j] && (req_reg[j].v0 != req_reg[j].v1))
            begin
                zdbad_w = 1'b1;
            end
        end
    end

    // Merge of the two lanes: the longest duration wins, a lost bracket counts
    // as no duration at all, and a joint that does not move counts as zero.
    assign ok0     = zd_reg[0] || !res[0].fail;
    assign ok1     = zd_reg[1] || !res[1].fail;
    assign t0      = zd_reg[0] ? '0 : res[0].dur;
    assign t1      = zd_reg[1] ? '0 : res[1].dur;
    assign tm_w    = (!ok0) ? t1 : ((!ok1) ? t0 : ((t0 > t1) ? t0 : t1));
    assign short_w = (!ok0 && !ok1) || (tm_w < TW'(TMIN_TICKS));

    genvar g;
    generate
        for (g = 0; g < 2; g++)
        begin : g_lane
            mtc_lane u_lane (
                .clk   (clk),
                .rst_n (rst_n),
                .start (lane_start),
                .req   (req_reg[g]),
                .res   (res[g])
            );
        end
    endgenerate

    // The coefficient stage takes the merged duration in the cycle it starts.
    mtc_coef u_coef (
        .clk   (clk),
        .rst_n (rst_n),
        .start (coef_start),
        .tm    (tm_w),
        .req   (req_reg),
        .done  (coef_done),
        .c1    (c1_w),
        .c2    (c2_w)
    );

    always_comb
    begin
        state_next  = state_reg;
        status_next = status_reg;
        tm_next     = tm_reg;
        lane_start  = 1'b0;
        coef_start  = 1'b0;
        load_ok     = 1'b0;
        case (state_reg)
            T_IDLE:
            begin
                if (accept)
                begin
                    state_next = T_CHECK;
                end
            end
            T_CHECK:
            begin
                if (over_w)
                begin
                    status_next = ST_OVER_SPEED;
                    state_next  = T_LOAD;
                end
                else if (zdbad_w)
                begin
                    status_next = ST_ZERO_DISP;
                    state_next  = T_LOAD;
                end
                else
                begin
                    status_next = ST_OK;
                    lane_start  = 1'b1;
                    state_next  = T_FIT;
                end
            end
            T_FIT:
            begin
                if (res[0].done && res[1].done)
                begin
                    state_next = T_MERGE;
                end
            end
            T_MERGE:
            begin
                if (short_w)
                begin
                    status_next = ST_TOO_SHORT;
                    state_next  = T_LOAD;
                end
                else
                begin
                    tm_next    = tm_w;
                    coef_start = 1'b1;
                    state_next = T_COEF;
                end
            end
            T_COEF:
            begin
                if (coef_done)
                begin
                    state_next = T_LOAD;
                end
            end
            T_LOAD:
            begin
                load_ok = !out_valid_reg || !out_stall;
                if (load_ok)
                begin
                    state_next = T_IDLE;
                end
            end
            default:
            begin
                state_next = T_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (load_ok)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= T_IDLE;
            status_reg    <= ST_OK;
            tm_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            status_reg    <= status_next;
            tm_reg        <= tm_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_reg[0] <= '{disp: disp_joint0, v0: start_speed_joint0,
                            v1: end_speed_joint0, vmax: vm0_reg};
            req_reg[1] <= '{disp: disp_joint1, v0: start_speed_joint1,
                            v1: end_speed_joint1, vmax: vm1_reg};
        end
        if (state_reg == T_CHECK)
        begin
            zd_reg[0] <= zd_w[0];
            zd_reg[1] <= zd_w[1];
        end
        if (load_ok)
        begin
            status_o_reg <= status_reg;
            for (int j = 0; j < 2; j++)
            begin
                if (status_reg == ST_OK)
                begin
                    c0_reg[j]   <= req_reg[j].v0;
                    c1_o_reg[j] <= c1_w[j];
                    c2_o_reg[j] <= c2_w[j];
                end
                else
                begin
                    c0_reg[j]   <= '0;
                    c1_o_reg[j] <= '0;
                    c2_o_reg[j] <= '0;
                end
            end
            duration_reg <= (status_reg == ST_OK) ? tm_reg : '0;
        end
    end

    assign out_valid         = out_valid_reg;
    assign status            = status_o_reg;
    assign duration          = duration_reg;
    assign coef_const_joint0 = c0_reg[0];
    assign coef_lin_joint0   = c1_o_reg[0];
    assign coef_quad_joint0  = c2_o_reg[0];
    assign coef_const_joint1 = c0_reg[1];
    assign coef_lin_joint1   = c1_o_reg[1];
    assign coef_quad_joint1  = c2_o_reg[1];

    `MTC_ASSERT_NEXT(a_accept_starts_check, clk, rst_n, accept, state_reg == T_CHECK,
        "accepted request did not enter the check step")
    `MTC_ASSERT_NEXT(a_load_sets_valid, clk, rst_n, load_ok, out_valid_reg && state_reg == T_IDLE,
        "result load did not present a word")
    `MTC_ASSERT_SAME(a_reject_zero_duration, clk, rst_n, out_valid_reg && status_o_reg != ST_OK,
        duration_reg == '0, "rejected result carries a duration")
    `MTC_ASSERT_SAME(a_ok_min_duration, clk, rst_n, out_valid_reg && status_o_reg == ST_OK,
        duration_reg >= TW'(TMIN_TICKS), "accepted result shorter than the minimum duration")

endmodule

// ===== sim/min_time_cubic_trajectory_fit_unit_checker.sv =====
// Checker for the trajectory fit unit: it tracks the speed limits, predicts one
// result word per request word and compares it with what the block returns.
// Depends on mtc_pkg for the field, coefficient and status types.
`timescale 1ns / 1ps

module min_time_cubic_trajectory_fit_unit_checker (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    input  logic            in_stall,
    input  mtc_pkg::field_t disp_joint0,
    input  mtc_pkg::field_t disp_joint1,
    input  mtc_pkg::field_t start_speed_joint0,
    input  mtc_pkg::field_t start_speed_joint1,
    input  mtc_pkg::field_t end_speed_joint0,
    input  mtc_pkg::field_t end_speed_joint1,
    input  logic            out_valid,
    input  logic            out_stall,
    input  logic [1:0]      status,
    input  logic [19:0]     duration,
    input  mtc_pkg::field_t coef_const_joint0,
    input  mtc_pkg::coef_t  coef_lin_joint0,
    input  mtc_pkg::coef_t  coef_quad_joint0,
    input  mtc_pkg::field_t coef_const_joint1,
    input  mtc_pkg::coef_t  coef_lin_joint1,
    input  mtc_pkg::coef_t  coef_quad_joint1,
    input  logic            cfg_valid,
    input  logic            cfg_ready,
    input  logic            cfg_index,
    input  logic [19:0]     cfg_data,
    output int              failures,
    output int              pending
);
    import mtc_pkg::*;

    localparam longint SC = SCALE;

    typedef struct {
        logic [1:0]  st;
        logic [19:0] dur;
        field_t      c0 [2];
        coef_t       c1 [2];
        coef_t       c2 [2];
    } fit_word_t;

    fit_word_t fit_queue [$];
    speed_t    limit_j0;
    speed_t    limit_j1;

    function automatic logic [127:0] abs128(input longint x);
        logic [127:0] r;
        r = (x < 0) ? -x : x;
        return r;
    endfunction

    // Sign of |v0 - a^2/(3b)| - vmax, evaluated exactly after scaling by 3b.
    function automatic int peak_over(input longint d, input longint v0, input longint v1,
                                     input longint vm, input longint t);
        longint a;
        longint bq;
        longint p;
        logic signed [127:0] pw;
        logic signed [127:0] bw;
        logic signed [127:0] aw;
        logic signed [127:0] xw;
        logic signed [127:0] rw;
        a  = 3 * d * SC - (2 * v0 + v1) * t;
        bq = -2 * d * SC + (v0 + v1) * t;
        if (bq == 0)
            return 1;
        p  = 3 * v0 * t;
        pw = p;
        bw = bq;
        aw = a;
        xw = pw * bw - aw * aw;
        if (xw < 0)
            xw = -xw;
        rw = 3 * vm * t;
        rw = rw * $signed(abs128(bq));
        return (xw > rw) ? 1 : ((xw < rw) ? -1 : 0);
    endfunction

    function automatic longint search_duration(input longint d, input longint v0,
                                               input longint v1, input longint vm);
        longint lo;
        longint hi;
        longint mid;
        int     y0;
        int     y1;
        int     y2;
        lo = TMIN_TICKS;
        hi = TMAX_TICKS;
        for (int i = 0; i < ITER_LIMIT; i++)
        begin
            mid = (lo + hi) >>> 1;
            y0 = peak_over(d, v0, v1, vm, lo);
            y1 = peak_over(d, v0, v1, vm, mid);
            y2 = peak_over(d, v0, v1, vm, hi);
            if (y0 * y2 > 0)
                return -1;
            if (y0 * y1 >= 0)
                lo = mid;
            if (y1 * y2 >= 0)
                hi = mid;
            if (((hi >= lo) ? hi - lo : lo - hi) < TOL_TICKS)
                return hi;
        end
        return hi;
    endfunction

    function automatic coef_t round_clip(input bit neg, input logic [127:0] num,
                                         input logic [127:0] den);
        logic [127:0] q;
        logic [127:0] lim;
        q   = (2 * num + den) / (2 * den);
        lim = neg ? 128'h80_0000_0000 : 128'h7F_FFFF_FFFF;
        if (q > lim)
            q = lim;
        return neg ? coef_t'(-q[39:0]) : coef_t'(q[39:0]);
    endfunction

    function automatic fit_word_t predict_fit(input longint d [2], input longint v0 [2],
                                              input longint v1 [2], input longint vm [2]);
        fit_word_t w;
        longint    tm;
        longint    tj;
        longint    a;
        longint    bq;
        w.st  = ST_OK;
        w.dur = '0;
        for (int j = 0; j < 2; j++)
        begin
            w.c0[j] = '0;
            w.c1[j] = '0;
            w.c2[j] = '0;
        end
        for (int j = 0; j < 2; j++)
            if ((v0[j] < 0 ? -v0[j] : v0[j]) > vm[j] || (v1[j] < 0 ? -v1[j] : v1[j]) > vm[j])
                w.st = ST_OVER_SPEED;
        if (w.st != ST_OK)
            return w;
        tm = -1;
        for (int j = 0; j < 2; j++)
        begin
            if ((d[j] < 0 ? -d[j] : d[j]) < TOL_TICKS)
            begin
                if (v0[j] != v1[j])
                begin
                    w.st = ST_ZERO_DISP;
                    return w;
                end
                tj = 0;
            end
            else
                tj = search_duration(d[j], v0[j], v1[j], vm[j]);
            if (tj > tm)
                tm = tj;
        end
        if (tm < TMIN_TICKS)
        begin
            w.st = ST_TOO_SHORT;
            return w;
        end
        w.dur = tm[19:0];
        for (int j = 0; j < 2; j++)
        begin
            a  = 3 * d[j] * SC - (2 * v0[j] + v1[j]) * tm;
            bq = -2 * d[j] * SC + (v0[j] + v1[j]) * tm;
            w.c0[j] = field_t'(v0[j]);
            w.c1[j] = round_clip(a < 0, 128'(2 * SC) * abs128(a), abs128(tm * tm));
            w.c2[j] = round_clip(bq < 0, 128'(3 * SC * SC) * abs128(bq),
                                 abs128(tm * tm) * abs128(tm));
        end
        return w;
    endfunction

    task automatic compare_field(input string name, input longint want, input longint got);
        if (want != got)
        begin
            $error("%s mismatch: expected %0d, actual %0d", name, want, got);
            failures++;
        end
    endtask

    assign pending = fit_queue.size();

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_j0 <= MAX_SPEED_RESET;
            limit_j1 <= MAX_SPEED_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            if (cfg_index == CFG_MAX_SPEED_J0)
                limit_j0 <= cfg_data;
            else
                limit_j1 <= cfg_data;
        end
    end

    initial
        failures = 0;

    always @(posedge clk)
    begin
        longint    d [2];
        longint    v0 [2];
        longint    v1 [2];
        longint    vm [2];
        fit_word_t w;
        if (rst_n && in_valid && !in_stall)
        begin
            d[0]  = disp_joint0;
            d[1]  = disp_joint1;
            v0[0] = start_speed_joint0;
            v0[1] = start_speed_joint1;
            v1[0] = end_speed_joint0;
            v1[1] = end_speed_joint1;
            vm[0] = limit_j0;
            vm[1] = limit_j1;
            fit_queue.push_back(predict_fit(d, v0, v1, vm));
        end
        if (rst_n && out_valid && !out_stall)
        begin
            if (fit_queue.size() == 0)
            begin
                $error("result word arrived with no request outstanding");
                failures++;
            end
            else
            begin
                w = fit_queue.pop_front();
                compare_field("status", w.st, status);
                compare_field("duration", w.dur, duration);
                compare_field("coef_const_joint0", w.c0[0], coef_const_joint0);
                compare_field("coef_lin_joint0", w.c1[0], coef_lin_joint0);
                compare_field("coef_quad_joint0", w.c2[0], coef_quad_joint0);
                compare_field("coef_const_joint1", w.c0[1], coef_const_joint1);
                compare_field("coef_lin_joint1", w.c1[1], coef_lin_joint1);
                compare_field("coef_quad_joint1", w.c2[1], coef_quad_joint1);
            end
        end
    end

endmodule

// ===== sim/min_time_cubic_trajectory_fit_unit_tb.sv =====
// Top of the trajectory fit unit testbench: clock, reset, speed limit phases,
// request stimulus, receiver back-pressure and the verdict.
// Depends on mtc_pkg, the block and min_time_cubic_trajectory_fit_unit_checker.
`timescale 1ns / 1ps

module min_time_cubic_trajectory_fit_unit_tb;
    import mtc_pkg::*;

    // The limit below leaves several times the headroom of a worst-case run with
    // its slowest requests and both idle draws.
    localparam int CYCLE_LIMIT  = 2_000_000;
    localparam int PHASE_ITEMS  = 80;
    localparam int LONG_HOLD    = 2500;
    localparam int HOLD_AT_WORD = 40;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    field_t      disp_joint0;
    field_t      disp_joint1;
    field_t      start_speed_joint0;
    field_t      start_speed_joint1;
    field_t      end_speed_joint0;
    field_t      end_speed_joint1;
    logic        out_valid;
    logic        out_stall;
    logic [1:0]  status;
    logic [19:0] duration;
    field_t      coef_const_joint0;
    coef_t       coef_lin_joint0;
    coef_t       coef_quad_joint0;
    field_t      coef_const_joint1;
    coef_t       coef_lin_joint1;
    coef_t       coef_quad_joint1;
    logic        cfg_valid;
    logic        cfg_ready;
    logic        cfg_index;
    logic [19:0] cfg_data;
    int          failures;
    int          pending;

    // The testbench keeps its own view of the limits so it can shape speeds.
    int          limit0;
    int          limit1;
    int          words_taken;
    int          item_no;

    min_time_cubic_trajectory_fit_unit uut (.*);

    min_time_cubic_trajectory_fit_unit_checker chk (.*);

    initial
    begin
        clk = 1'b0;
        forever
            #6 clk = ~clk;
    end

    // Hard stop in case the block hangs or loses a word.
    initial
    begin
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("RESULT: ERROR");
        $finish;
    end

    // Writes one speed limit register; the channel's ready is honored even
    // though the block always accepts.
    task automatic write_limit(input logic idx, input int value);
        logic ok;
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value[19:0];
        do
        begin
            @(negedge clk);
            ok = cfg_ready;
            @(posedge clk);
        end
        while (!ok);
        cfg_valid <= 1'b0;
        if (idx == CFG_MAX_SPEED_J0)
            limit0 = value;
        else
            limit1 = value;
    endtask

    // Offers one request word after an idle gap and returns at the edge that
    // accepts it. The caller is always on a rising edge, so valid is never
    // lowered and raised in the same step.
    task automatic send_request(input int d0, input int d1, input int s0, input int s1,
                                input int e0, input int e1, input int gap);
        logic ok;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        disp_joint0        <= field_t'(d0);
        disp_joint1        <= field_t'(d1);
        start_speed_joint0 <= field_t'(s0);
        start_speed_joint1 <= field_t'(s1);
        end_speed_joint0   <= field_t'(e0);
        end_speed_joint1   <= field_t'(e1);
        in_valid           <= 1'b1;
        do
        begin
            @(negedge clk);
            ok = !in_stall;
            @(posedge clk);
        end
        while (!ok);
        item_no++;
    endtask

    // Sender gap: every third block of forty items runs with no idling at all.
    function automatic int sender_gap();
        return ((item_no / 40) % 3 == 2) ? 0 : $urandom_range(0, 16);
    endfunction

    function automatic int full_range();
        return $urandom_range(0, 1048576) - 524288;
    endfunction

    // Mostly speeds within the joint's limit, so requests get past the limit
    // check and into the search; now and then anything the field allows.
    function automatic int pick_speed(input int lim);
        if ($urandom_range(0, 99) < 88)
            return $urandom_range(0, 2 * lim) - lim;
        return full_range();
    endfunction

    task automatic send_random();
        int d [2];
        int s [2];
        int e [2];
        int lim [2];
        lim[0] = limit0;
        lim[1] = limit1;
        for (int j = 0; j < 2; j++)
        begin
            s[j] = pick_speed(lim[j]);
            e[j] = ($urandom_range(0, 9) == 0) ? s[j] : pick_speed(lim[j]);
            if ($urandom_range(0, 9) == 0)
            begin
                // Near-zero displacement, usually with matching speeds.
                d[j] = $urandom_range(0, 130) - 65;
                if ($urandom_range(0, 3) != 0)
                    e[j] = s[j];
            end
            else if ($urandom_range(0, 3) == 0)
                d[j] = $urandom_range(0, 20000) - 10000;
            else
                d[j] = full_range();
        end
        send_request(d[0], d[1], s[0], s[1], e[0], e[1], sender_gap());
    endtask

    // Closes a phase: the last word is lowered, then every result must be back
    // before the limits change. The checker counts the last word at its
    // accepting edge, so the outstanding count is read on the falling edge after it.
    task automatic drain();
        in_valid <= 1'b0;
        @(negedge clk);
        wait (pending == 0);
        @(posedge clk);
    endtask

    // Receiver: a random stall before each result word, none in every fourth block of
    // fifty words, and one long hold-off so the block fills up and has to stall its input.
    initial
    begin
        int n;
        logic ok;
        out_stall   = 1'b0;
        words_taken = 0;
        @(posedge rst_n);
        @(posedge clk);
        forever
        begin
            if (words_taken == HOLD_AT_WORD)
                n = LONG_HOLD;
            else if ((words_taken / 50) % 4 == 3)
                n = 0;
            else
                n = $urandom_range(0, 16);
            if (n > 0)
            begin
                out_stall <= 1'b1;
                repeat (n) @(posedge clk);
            end
            out_stall <= 1'b0;
            do
            begin
                @(negedge clk);
                ok = out_valid;
                @(posedge clk);
            end
            while (!ok);
            words_taken++;
        end
    end

    initial
    begin
        int setting [4][2];
        rst_n              = 1'b0;
        in_valid           = 1'b0;
        disp_joint0        = '0;
        disp_joint1        = '0;
        start_speed_joint0 = '0;
        start_speed_joint1 = '0;
        end_speed_joint0   = '0;
        end_speed_joint1   = '0;
        cfg_valid          = 1'b0;
        cfg_index          = CFG_MAX_SPEED_J0;
        cfg_data           = '0;
        limit0             = MAX_SPEED_RESET;
        limit1             = MAX_SPEED_RESET;
        item_no            = 0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed words at the reset limits of 2.5 per joint.
        send_request(0, 0, 0, 0, 0, 0, 0);                          // all still: too short
        send_request(524288, 0, 0, 0, 0, 0, 0);                     // largest displacement
        send_request(-524288, 524288, 0, 0, 0, 0, 3);
        send_request(65536, 65536, 163841, 0, 0, 0, 0);             // start over the limit
        send_request(65536, 65536, 0, 0, 0, -163841, 0);            // end over the limit
        send_request(65536, 0, -524288, 524288, -524288, 524288, 0);
        send_request(10, 65536, 100, 0, 200, 0, 1);                 // still joint, speed change
        send_request(65536, -10, 0, 100, 0, 50, 0);                 // same on the second joint
        send_request(65, 100000, 1000, 0, 1000, 0, 0);              // still joint, equal speeds
        send_request(66, -66, 0, 0, 0, 0, 0);                       // displacement at tolerance
        send_request(524288, -524288, 163840, -163840, 163840, -163840, 2);
        send_request(300000, 300000, -163840, 163840, 163840, -163840, 0);
        send_request(6554, 0, 65536, 0, 65536, 0, 0);               // divisor zero at 0.1 s
        send_request(70000, 70000, -163840, -163840, -163840, -163840, 0); // lost bracket
        send_request(100, 200, 0, 0, 0, 0, 0);                      // very short motion
        send_request(-1000, 1000, 163840, 0, -163840, 0, 0);
        send_request(1048575 - 524287, -3, 5, 5, 5, 5, 0);
        send_request(-1, 1, 0, 0, 0, 0, 0);
        for (int i = 0; i < PHASE_ITEMS; i++)
            send_random();
        drain();

        // Limit settings: both at the top, both at zero, one minimal and one
        // maximal, then random.
        setting[0] = '{524288, 524288};
        setting[1] = '{0, 0};
        setting[2] = '{1, 524288};
        setting[3] = '{$urandom_range(0, 524288), $urandom_range(0, 524288)};
        for (int ph = 0; ph < 4; ph++)
        begin
            write_limit(CFG_MAX_SPEED_J0, setting[ph][0]);
            write_limit(CFG_MAX_SPEED_J1, setting[ph][1]);
            if (ph == 0)
                send_request(524288, -524288, 524288, -524288, -524288, 524288, 0);
            for (int i = 0; i < PHASE_ITEMS; i++)
                send_random();
            drain();
        end

        repeat (50) @(posedge clk);
        if (failures == 0 && pending == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
